// ----- design/task_timing_statistics_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// Task timing statistics monitor: assertion macros
// Shared concurrent assertion forms for the monitor's RTL files.
// ----------------------------------------------------------------------------
`ifndef TASK_TIMING_STATISTICS_MONITOR_MACROS_SVH
`define TASK_TIMING_STATISTICS_MONITOR_MACROS_SVH

// Checked on every rising edge, skipped while reset is asserted.
`define TTSM_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TTSM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ttsm_pkg.sv -----
// ----------------------------------------------------------------------------
// ttsm_pkg
// Shared types and constants of the task timing statistics monitor.
// ----------------------------------------------------------------------------
package ttsm_pkg;

    // Number of measured tasks and the width of a task's storage index.
    localparam int TASK_COUNT = 4;
    localparam int TASK_W     = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    // Field widths fixed by the item format.
    localparam int OPCODE_W   = 2;
    localparam int TASK_IDX_W = 2;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 288;

    // Cycle to microsecond shift after reset.
    localparam logic [3:0] SHIFT_RESET = 4'd6;

    // Statistic reset values.
    localparam logic signed [31:0] INT32_MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN_C = 32'sh8000_0000;
    localparam logic [30:0]        MIN31_C     = 31'h7FFF_FFFF;

    // Configuration register index (byte address bit 2).
    localparam logic REG_CYCLES_SHIFT = 1'b0;

    // Divider: one quotient bit per step over a 64-bit dividend.
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Item operations.
    typedef enum logic [OPCODE_W-1:0] {
        OP_SLICE_END = 2'd0,
        OP_JOB_BEGIN = 2'd1,
        OP_JOB_END   = 2'd2,
        OP_REPORT    = 2'd3
    } opcode_t;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/ttsm_div.sv -----
// ----------------------------------------------------------------------------
// ttsm_div
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttsm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         dividend,
    input  logic [31:0]         divisor,
    output ttsm_pkg::div_stat_t stat,
    output logic [63:0]         quotient
);

    logic [31:0]                    rem_reg;
    logic [63:0]                    quo_reg;
    logic [31:0]                    div_reg;
    logic [ttsm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_next;

    // One shift-and-subtract step: the next dividend bit enters the remainder.
    always_comb begin
        shifted  = {rem_reg, quo_reg[63]};
        ge       = (shifted >= {1'b0, div_reg});
        diff     = shifted - {1'b0, div_reg};
        rem_next = ge ? diff[31:0] : shifted[31:0];
    end

    // Step control; the quotient register doubles as the dividend shifter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                div_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[62:0], ge};
                cnt_reg <= cnt_reg + ttsm_pkg::DIV_CNT_W'(1);
                if (cnt_reg == ttsm_pkg::DIV_CNT_W'(ttsm_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- design/task_timing_statistics_monitor.sv -----
// Slice end and job begin run EXEC and return to IDLE; job end adds UPD, an empty report DONE.
// A report with jobs runs EXEC, DIVJ, DIVC and DONE, its result loaded in DONE:
// the shared one-bit-per-cycle divider runs twice, 64 steps for the jitter average
// and 64 for the compute average.
// Items are taken one at a time; a result held in the output register stalls only a report.
// Reset (aresetn low, synchronous) restores cycles_shift to 6 and all task statistics.
// ----------------------------------------------------------------------------
// task_timing_statistics_monitor
// Per-task timing statistics: jitter, compute time, response and deadline
// misses, reported with truncating averages and cleared on report.
// ----------------------------------------------------------------------------
`include "task_timing_statistics_monitor_macros.svh"

module task_timing_statistics_monitor (
    input  logic         aclk,
    input  logic         aresetn,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    // task_index[1:0], release_jitter[33:2], slice_cycles[65:34], resp_time[97:66],
    // deadline_limit[129:98], zero fill above
    input  logic [ttsm_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    // min_jitter[31:0], max_jitter[63:32], mean_jitter[95:64], jobs_seen[127:96],
    // misses_seen[159:128], max_response[191:160], max_compute[223:192],
    // min_compute[254:224], avg_compute[286:255], zero fill above
    output logic [ttsm_pkg::M_TDATA_W-1:0] m_tdata,
    // report_empty[0]
    output logic         m_tuser,
    // Configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int TC = ttsm_pkg::TASK_COUNT;
    localparam int TW = ttsm_pkg::TASK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_UPD,
        S_DIVJ,
        S_DIVC,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [3:0]              shift_reg;
    ttsm_pkg::opcode_t       op_reg;
    logic [TW-1:0]           task_reg;
    logic signed [31:0]      jit_reg;
    logic [31:0]             slice_reg;
    logic [31:0]             resp_reg;
    logic [31:0]             dl_reg;
    logic [31:0]             comp_reg;
    logic                    neg_reg;
    logic                    empty_reg;
    logic [31:0]             avgj_reg;
    logic [31:0]             avgc_reg;

    // Per-task state
    logic [31:0]             accum_reg [TC];
    logic signed [31:0]      jmin_reg  [TC];
    logic signed [31:0]      jmax_reg  [TC];
    logic [63:0]             jsum_reg  [TC];
    logic [31:0]             jobs_reg  [TC];
    logic [31:0]             miss_reg  [TC];
    logic [31:0]             rmax_reg  [TC];
    logic [31:0]             cmax_reg  [TC];
    logic [30:0]             cmin_reg  [TC];
    logic [63:0]             csum_reg  [TC];

    logic                    m_tvalid_reg;
    logic [ttsm_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    // Input field views
    logic [ttsm_pkg::TASK_IDX_W-1:0] s_task;
    logic                    in_range;
    logic                    s_accept;
    logic                    cfg_write;
    logic                    out_load;

    // Datapath helpers
    logic [31:0]             acc_sum;
    logic [31:0]             comp_next;
    logic [30:0]             comp_sat;
    logic [63:0]             jsum_cur;
    logic [63:0]             jmag;
    logic [31:0]             qlow;

    // Shared divider
    logic                    div_start;
    logic [63:0]             div_dividend;
    ttsm_pkg::div_stat_t     div_stat;
    logic [63:0]             div_q;

    assign s_task    = s_tdata[ttsm_pkg::TASK_IDX_W-1:0];
    assign in_range  = (32'(s_task) < 32'(TC));
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Arithmetic on the selected task's entries.
    always_comb begin
        acc_sum   = accum_reg[task_reg] + slice_reg;
        comp_next = acc_sum >> shift_reg;
        comp_sat  = comp_reg[31] ? ttsm_pkg::MIN31_C : comp_reg[30:0];
        jsum_cur  = jsum_reg[task_reg];
        jmag      = jsum_cur[63] ? (64'd0 - jsum_cur) : jsum_cur;
        qlow      = div_q[31:0];
    end

    // Divider feed: jitter magnitude first, then the compute sum.
    assign div_start    = ((state_reg == S_EXEC) && (op_reg == ttsm_pkg::OP_REPORT) &&
                           (jobs_reg[task_reg] != 32'd0)) ||
                          ((state_reg == S_DIVJ) && div_stat.done);
    assign div_dividend = (state_reg == S_EXEC) ? jmag : csum_reg[task_reg];

    ttsm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (jobs_reg[task_reg]),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Sequencer, task state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            shift_reg    <= ttsm_pkg::SHIFT_RESET;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < TC; i++) begin
                accum_reg[i] <= '0;
                jmin_reg[i]  <= ttsm_pkg::INT32_MAX_C;
                jmax_reg[i]  <= ttsm_pkg::INT32_MIN_C;
                jsum_reg[i]  <= '0;
                jobs_reg[i]  <= '0;
                miss_reg[i]  <= '0;
                rmax_reg[i]  <= '0;
                cmax_reg[i]  <= '0;
                cmin_reg[i]  <= ttsm_pkg::MIN31_C;
                csum_reg[i]  <= '0;
            end
        end else begin
            // Configuration write.
            if (cfg_write && (paddr[2] == ttsm_pkg::REG_CYCLES_SHIFT)) begin
                shift_reg <= pwdata[3:0];
            end

            // A finished report is loaded, or the held result is taken downstream.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_accept && in_range) begin
                        op_reg    <= ttsm_pkg::opcode_t'(s_tuser);
                        task_reg  <= s_task[TW-1:0];
                        jit_reg   <= s_tdata[33:2];
                        slice_reg <= s_tdata[65:34];
                        resp_reg  <= s_tdata[97:66];
                        dl_reg    <= s_tdata[129:98];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (op_reg)
                        ttsm_pkg::OP_SLICE_END: begin
                            accum_reg[task_reg] <= acc_sum;
                            state_reg <= S_IDLE;
                        end
                        ttsm_pkg::OP_JOB_BEGIN: begin
                            accum_reg[task_reg] <= '0;
                            if (jit_reg < jmin_reg[task_reg]) jmin_reg[task_reg] <= jit_reg;
                            if (jit_reg > jmax_reg[task_reg]) jmax_reg[task_reg] <= jit_reg;
                            jsum_reg[task_reg] <= jsum_cur + 64'(jit_reg);
                            jobs_reg[task_reg] <= jobs_reg[task_reg] + 32'd1;
                            state_reg <= S_IDLE;
                        end
                        ttsm_pkg::OP_JOB_END: begin
                            comp_reg  <= comp_next;
                            state_reg <= S_UPD;
                        end
                        ttsm_pkg::OP_REPORT: begin
                            if (jobs_reg[task_reg] == 32'd0) begin
                                empty_reg <= 1'b1;
                                state_reg <= S_DONE;
                            end else begin
                                empty_reg <= 1'b0;
                                neg_reg   <= jsum_cur[63];
                                state_reg <= S_DIVJ;
                            end
                        end
                        default: begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_UPD: begin
                    // Job end: compute time and response statistics.
                    if (comp_reg > cmax_reg[task_reg]) cmax_reg[task_reg] <= comp_reg;
                    if (comp_sat < cmin_reg[task_reg]) cmin_reg[task_reg] <= comp_sat;
                    csum_reg[task_reg] <= csum_reg[task_reg] + {32'd0, comp_reg};
                    if (resp_reg > rmax_reg[task_reg]) rmax_reg[task_reg] <= resp_reg;
                    if ((dl_reg != 32'd0) && (resp_reg > dl_reg)) begin
                        miss_reg[task_reg] <= miss_reg[task_reg] + 32'd1;
                    end
                    state_reg <= S_IDLE;
                end
                S_DIVJ: begin
                    if (div_stat.done) begin
                        avgj_reg  <= neg_reg ? (32'd0 - qlow) : qlow;
                        state_reg <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (div_stat.done) begin
                        avgc_reg  <= qlow;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Load the result once the output register is free.
                    if (out_load) begin
                        m_tuser_reg  <= empty_reg;
                        if (empty_reg) begin
                            m_tdata_reg <= '0;
                        end else begin
                            m_tdata_reg <= {1'b0, avgc_reg, cmin_reg[task_reg],
                                            cmax_reg[task_reg], rmax_reg[task_reg],
                                            miss_reg[task_reg], jobs_reg[task_reg],
                                            avgj_reg, jmax_reg[task_reg],
                                            jmin_reg[task_reg]};
                            jmin_reg[task_reg] <= ttsm_pkg::INT32_MAX_C;
                            jmax_reg[task_reg] <= ttsm_pkg::INT32_MIN_C;
                            jsum_reg[task_reg] <= '0;
                            jobs_reg[task_reg] <= '0;
                            miss_reg[task_reg] <= '0;
                            rmax_reg[task_reg] <= '0;
                            cmax_reg[task_reg] <= '0;
                            cmin_reg[task_reg] <= ttsm_pkg::MIN31_C;
                            csum_reg[task_reg] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ttsm_pkg::REG_CYCLES_SHIFT) ? {28'd0, shift_reg} : 32'd0;

    // Checks
    `TTSM_ASSERT(a_div_start_idle, aclk, aresetn, div_start |-> !div_stat.busy, "divider restarted while busy")
    `TTSM_ASSERT(a_ready_div_idle, aclk, aresetn, s_tready |-> !div_stat.busy, "item accepted during a division")
    `TTSM_ASSERT(a_accept_stalls, aclk, aresetn, (s_tvalid && s_tready && in_range) |=> !s_tready, "accepted item did not hold off input")
    `TTSM_ASSERT(a_empty_zero, aclk, aresetn, (m_tvalid && m_tuser) |-> (m_tdata == '0), "empty report carries data")
    `TTSM_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (s_tready && !m_tvalid), "reset did not return to idle")

endmodule

// ----- tb/task_timing_statistics_monitor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_timing_statistics_monitor_tb
// Self-checking bench for the task timing statistics monitor. Directed items
// cover empty reports, wrap-around of the cycle accumulator, saturation of
// the minimum compute time and the accumulator surviving a report. Random
// job sequences then run under several shift settings and several patterns
// of sender gaps and receiver stalls. Every report is checked field by field
// against a model of the per-task statistics kept inside the bench.
// ----------------------------------------------------------------------------
module task_timing_statistics_monitor_tb;

    localparam int HOLD_OFF_CYCLES = 150;
    localparam logic [2:0] ADDR_CYCLES_SHIFT = {ttsm_pkg::REG_CYCLES_SHIFT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

    // One statistics report as it leaves the block.
    typedef struct packed {
        logic               empty;
        logic signed [31:0] min_jitter;
        logic signed [31:0] max_jitter;
        logic signed [31:0] mean_jitter;
        logic [31:0]        jobs_seen;
        logic [31:0]        misses_seen;
        logic [31:0]        max_response;
        logic [31:0]        max_compute;
        logic [30:0]        min_compute;
        logic [31:0]        avg_compute;
    } stat_report_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic         m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Bench-side copy of the block's state.
    logic [3:0]         cur_shift;
    logic [31:0]        accum_cycles [ttsm_pkg::TASK_COUNT];
    logic signed [31:0] jit_lo       [ttsm_pkg::TASK_COUNT];
    logic signed [31:0] jit_hi       [ttsm_pkg::TASK_COUNT];
    logic [63:0]        jit_total    [ttsm_pkg::TASK_COUNT];
    logic [31:0]        job_cnt      [ttsm_pkg::TASK_COUNT];
    logic [31:0]        miss_cnt     [ttsm_pkg::TASK_COUNT];
    logic [31:0]        resp_hi      [ttsm_pkg::TASK_COUNT];
    logic [31:0]        comp_hi      [ttsm_pkg::TASK_COUNT];
    logic [30:0]        comp_lo      [ttsm_pkg::TASK_COUNT];
    logic [63:0]        comp_total   [ttsm_pkg::TASK_COUNT];

    stat_report_t expected_reports[$];
    int           error_count      = 0;
    int           sender_idle_pct  = 0;
    int           receiver_stall_pct = 0;
    int           events_sent      = 0;

    task_timing_statistics_monitor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Random receiver back-pressure.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Restore the statistics window of one task.
    function automatic void clear_window(input int id);
        jit_lo[id]     = ttsm_pkg::INT32_MAX_C;
        jit_hi[id]     = ttsm_pkg::INT32_MIN_C;
        jit_total[id]  = '0;
        job_cnt[id]    = '0;
        miss_cnt[id]   = '0;
        resp_hi[id]    = '0;
        comp_hi[id]    = '0;
        comp_lo[id]    = ttsm_pkg::MIN31_C;
        comp_total[id] = '0;
    endfunction

    // Update the statistics for one item; returns 1 when a report comes out.
    function automatic bit update_statistics(input ttsm_pkg::opcode_t op,
                                             input logic [1:0] id,
                                             input logic signed [31:0] jit,
                                             input logic [31:0] slice, resp, dl,
                                             output stat_report_t rep);
        logic [31:0] comp;
        logic [30:0] comp_floor;
        logic [63:0] mag;
        logic [63:0] quo;
        bit          produced;
        rep = '0;
        produced = 1'b0;
        case (op)
            ttsm_pkg::OP_SLICE_END: begin
                accum_cycles[id] = accum_cycles[id] + slice;
            end
            ttsm_pkg::OP_JOB_BEGIN: begin
                accum_cycles[id] = '0;
                if (jit < jit_lo[id]) jit_lo[id] = jit;
                if (jit > jit_hi[id]) jit_hi[id] = jit;
                jit_total[id] = jit_total[id] + {{32{jit[31]}}, jit};
                job_cnt[id]   = job_cnt[id] + 1;
            end
            ttsm_pkg::OP_JOB_END: begin
                comp = (accum_cycles[id] + slice) >> cur_shift;
                comp_floor = (comp > {1'b0, ttsm_pkg::MIN31_C}) ? ttsm_pkg::MIN31_C
                                                                 : comp[30:0];
                if (comp > comp_hi[id]) comp_hi[id] = comp;
                if (comp_floor < comp_lo[id]) comp_lo[id] = comp_floor;
                comp_total[id] = comp_total[id] + {32'b0, comp};
                if (resp > resp_hi[id]) resp_hi[id] = resp;
                if (dl != 0 && resp > dl) miss_cnt[id] = miss_cnt[id] + 1;
            end
            default: begin
                produced = 1'b1;
                if (job_cnt[id] == 0) begin
                    rep.empty = 1'b1;
                end else begin
                    // Signed average truncates toward zero.
                    mag = jit_total[id][63] ? -jit_total[id] : jit_total[id];
                    quo = mag / {32'b0, job_cnt[id]};
                    if (jit_total[id][63]) quo = -quo;
                    rep.min_jitter   = jit_lo[id];
                    rep.max_jitter   = jit_hi[id];
                    rep.mean_jitter  = quo[31:0];
                    rep.jobs_seen    = job_cnt[id];
                    rep.misses_seen  = miss_cnt[id];
                    rep.max_response = resp_hi[id];
                    rep.max_compute  = comp_hi[id];
                    rep.min_compute  = comp_lo[id];
                    quo = comp_total[id] / {32'b0, job_cnt[id]};
                    rep.avg_compute  = quo[31:0];
                    clear_window(id);
                end
            end
        endcase
        return produced;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each result item with the oldest pending report.
    always @(posedge aclk) begin : report_checker
        stat_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result item with no report pending");
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("report_empty", {31'b0, want.empty}, {31'b0, m_tuser});
                check_field("min_jitter",   want.min_jitter,   m_tdata[31:0]);
                check_field("max_jitter",   want.max_jitter,   m_tdata[63:32]);
                check_field("mean_jitter",  want.mean_jitter,  m_tdata[95:64]);
                check_field("jobs_seen",    want.jobs_seen,    m_tdata[127:96]);
                check_field("misses_seen",  want.misses_seen,  m_tdata[159:128]);
                check_field("max_response", want.max_response, m_tdata[191:160]);
                check_field("max_compute",  want.max_compute,  m_tdata[223:192]);
                check_field("min_compute",  {1'b0, want.min_compute},
                            {1'b0, m_tdata[254:224]});
                check_field("avg_compute",  want.avg_compute,  m_tdata[286:255]);
            end
        end
    end

    // Send one item; called and returning at a falling edge.
    task automatic send_event(input ttsm_pkg::opcode_t op, input logic [1:0] id,
                              input logic signed [31:0] jit, input logic [31:0] slice,
                              input logic [31:0] resp, input logic [31:0] dl);
        stat_report_t rep;
        while ($urandom_range(99) < sender_idle_pct) @(negedge aclk);
        s_tuser  = op;
        s_tdata  = {6'b0, dl, resp, slice, jit, id};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (update_statistics(op, id, jit, slice, resp, dl, rep))
            expected_reports.push_back(rep);
        events_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_reports_done();
        while (expected_reports.size() != 0) @(negedge aclk);
    endtask

    // Let the block finish any item that yields no result.
    task automatic wait_block_idle();
        wait_reports_done();
        repeat (HOLD_OFF_CYCLES) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_CYCLES_SHIFT) cur_shift = data[3:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_shift();
        logic [31:0] got;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_CYCLES_SHIFT;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field("cycles_shift", {28'b0, cur_shift}, got);
    endtask

    // Change the shift once the block is idle; upper data bits are junk.
    task automatic set_cycles_shift(input logic [3:0] value);
        wait_block_idle();
        apb_write(ADDR_CYCLES_SHIFT, {28'($urandom_range(0, 32'h0FFF_FFFF)), value});
        apb_read_shift();
    endtask

    function automatic logic [31:0] rand_cycles();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(0, 200000);
    endfunction

    function automatic logic [31:0] rand_span();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(0, 5000);
    endfunction

    function automatic logic signed [31:0] rand_jitter();
        logic signed [31:0] v;
        if ($urandom_range(3) == 0) return $urandom;
        v = $urandom_range(0, 2000);
        return v - 1000;
    endfunction

    // A report of a task that never began a job.
    task automatic test_empty_report();
        send_event(ttsm_pkg::OP_REPORT, 2'd0, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Jitter and duration extremes, a wrapping accumulator and deadline edges.
    task automatic test_wrap_extremes();
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd1, ttsm_pkg::INT32_MIN_C, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_SLICE_END, 2'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd1, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd1, ttsm_pkg::INT32_MAX_C, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd1, 32'sd0, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd1, 32'd0, 32'd64, 32'd100, 32'd100);
        send_event(ttsm_pkg::OP_REPORT, 2'd1, 32'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // Shift of zero lets compute exceed 31 bits; the largest shift follows.
    task automatic test_saturated_compute();
        set_cycles_shift(4'd0);
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd2, -32'sd1, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_SLICE_END, 2'd2, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd2, 32'd0, 32'h7FFF_FFFF, 32'd7, 32'd3);
        send_event(ttsm_pkg::OP_REPORT, 2'd2, 32'd0, 32'd0, 32'd0, 32'd0);
        set_cycles_shift(4'd15);
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd2, 32'sd3, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd2, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd9);
        send_event(ttsm_pkg::OP_REPORT, 2'd2, 32'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // A report clears the window but keeps the cycle accumulator.
    task automatic test_accumulator_kept();
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd3, -32'sd7, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_SLICE_END, 2'd3, 32'd0, 32'h4000_0000, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_REPORT, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_END, 2'd3, 32'd0, 32'd0, 32'd12, 32'd0);
        send_event(ttsm_pkg::OP_REPORT, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_JOB_BEGIN, 2'd3, -32'sd8, 32'd0, 32'd0, 32'd0);
        send_event(ttsm_pkg::OP_REPORT, 2'd3, 32'd0, 32'd0, 32'd0, 32'd0);
    endtask

    // A write outside the register map must leave the shift unchanged.
    task automatic test_register_access();
        wait_block_idle();
        apb_write(ADDR_UNMAPPED, $urandom);
        apb_read_shift();
        set_cycles_shift(ttsm_pkg::SHIFT_RESET);
    endtask

    // Well-formed jobs with random content, mixed with random noise items.
    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [3:0] shift, input int budget);
        int          start_count;
        int          jobs_done;
        logic [1:0]  id;
        logic [31:0] resp;
        logic [31:0] dl;
        set_cycles_shift(shift);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count = events_sent;
        jobs_done   = 0;
        while (events_sent - start_count < budget) begin
            id = $urandom_range(ttsm_pkg::TASK_COUNT - 1);
            if ($urandom_range(99) < 10) begin
                send_event(ttsm_pkg::opcode_t'($urandom_range(3)), id, $urandom, $urandom,
                           $urandom, $urandom);
            end else begin
                send_event(ttsm_pkg::OP_JOB_BEGIN, id, rand_jitter(), $urandom, $urandom,
                           $urandom);
                repeat ($urandom_range(0, 3))
                    send_event(ttsm_pkg::OP_SLICE_END, id, $urandom, rand_cycles(),
                               $urandom, $urandom);
                resp = rand_span();
                case ($urandom_range(3))
                    0:       dl = 32'd0;
                    1:       dl = resp;
                    default: dl = rand_span();
                endcase
                send_event(ttsm_pkg::OP_JOB_END, id, $urandom, rand_cycles(), resp, dl);
                if ($urandom_range(2) == 0)
                    send_event(ttsm_pkg::OP_REPORT, id, $urandom, $urandom, $urandom,
                               $urandom);
                jobs_done++;
                // Now and then hold the sender until every report is back.
                if (jobs_done % 25 == 24) wait_reports_done();
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(0,  0,  4'd6, 325);
        run_random_phase(61, 0,  4'd0, 325);
        run_random_phase(0,  61, 4'd15, 325);
        run_random_phase(25, 25, 4'($urandom_range(1, 14)), 325);
    endtask

    initial begin
        cur_shift = ttsm_pkg::SHIFT_RESET;
        for (int i = 0; i < ttsm_pkg::TASK_COUNT; i++) begin
            accum_cycles[i] = '0;
            clear_window(i);
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_report();
        test_wrap_extremes();
        test_saturated_compute();
        test_accumulator_kept();
        test_register_access();
        test_random_traffic();

        wait_block_idle();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a lost report.
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
